// ===== hw/rtl/avt_pkg.sv =====
`default_nettype none

package avt_pkg;

  // Coefficient and translation slots are always 16 bits wide.
  localparam int SLOT_BITS  = 16;
  localparam int DIMS       = 3;
  localparam int CFG_ADDR_W = 6;
  localparam int CFG_DATA_W = 64;
  localparam int ROW_W      = DIMS * SLOT_BITS;

  // Per-stage load enables of the transform pipeline.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } avt_en_t;

endpackage

`default_nettype wire

// ===== hw/rtl/avt_regs.sv =====
`default_nettype none

module avt_regs #(
  parameter int COEF_FRAC_BITS = 12
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [avt_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [avt_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic      [avt_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                                 pready,
  output logic      [avt_pkg::ROW_W-1:0]       row_zero,
  output logic      [avt_pkg::ROW_W-1:0]       row_one,
  output logic      [avt_pkg::ROW_W-1:0]       row_two,
  output logic      [avt_pkg::ROW_W-1:0]       translation_row,
  output logic                                 add_translation
);
  import avt_pkg::*;

  typedef enum logic [2:0] {
    REG_ROW_ZERO    = 3'd0,
    REG_ROW_ONE     = 3'd1,
    REG_ROW_TWO     = 3'd2,
    REG_TRANSLATION = 3'd3,
    REG_ADD_TRANS   = 3'd4
  } avt_reg_t;

  localparam logic [ROW_W-1:0] UNIT = ROW_W'(1) << COEF_FRAC_BITS;

  avt_reg_t reg_sel;
  logic     wr;

  assign reg_sel = avt_reg_t'(paddr[5:3]);
  assign wr      = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_zero        <= UNIT;
      row_one         <= UNIT << SLOT_BITS;
      row_two         <= UNIT << (2 * SLOT_BITS);
      translation_row <= '0;
      add_translation <= 1'b1;
    end else if (wr) begin
      case (reg_sel)
        REG_ROW_ZERO:    row_zero        <= pwdata[ROW_W-1:0];
        REG_ROW_ONE:     row_one         <= pwdata[ROW_W-1:0];
        REG_ROW_TWO:     row_two         <= pwdata[ROW_W-1:0];
        REG_TRANSLATION: translation_row <= pwdata[ROW_W-1:0];
        REG_ADD_TRANS:   add_translation <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_ROW_ZERO:    prdata = CFG_DATA_W'(row_zero);
      REG_ROW_ONE:     prdata = CFG_DATA_W'(row_one);
      REG_ROW_TWO:     prdata = CFG_DATA_W'(row_two);
      REG_TRANSLATION: prdata = CFG_DATA_W'(translation_row);
      REG_ADD_TRANS:   prdata = CFG_DATA_W'(add_translation);
      default:         prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/avt_lane.sv =====
`default_nettype none

// One output component: multiply, sum, then round and saturate.
module avt_lane #(
  parameter int COORD_WIDTH    = 16,
  parameter int COEF_FRAC_BITS = 12
) (
  input  wire logic                                 clk,
  input  wire avt_pkg::avt_en_t                     en,
  input  wire logic signed [COORD_WIDTH-1:0]        x,
  input  wire logic signed [COORD_WIDTH-1:0]        y,
  input  wire logic signed [COORD_WIDTH-1:0]        z,
  input  wire logic signed [avt_pkg::SLOT_BITS-1:0] c0,
  input  wire logic signed [avt_pkg::SLOT_BITS-1:0] c1,
  input  wire logic signed [avt_pkg::SLOT_BITS-1:0] c2,
  input  wire logic signed [avt_pkg::SLOT_BITS-1:0] t,
  input  wire logic                                 add_t,
  output logic signed      [COORD_WIDTH-1:0]        res,
  output logic                                      sat
);
  import avt_pkg::*;

  localparam int P_W  = COORD_WIDTH + SLOT_BITS;
  localparam int T_W  = SLOT_BITS + COEF_FRAC_BITS + 1;
  localparam int G_W  = COORD_WIDTH + COEF_FRAC_BITS + 1;
  localparam int M_W  = (P_W > T_W) ? ((P_W > G_W) ? P_W : G_W) : ((T_W > G_W) ? T_W : G_W);
  localparam int ACC_W = M_W + 2;
  localparam int R_W  = ACC_W - COEF_FRAC_BITS;

  localparam logic signed [R_W-1:0] HI = R_W'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
  localparam logic signed [R_W-1:0] LO = ~HI;
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);

  logic signed [P_W-1:0]   m0, m1, m2;
  logic signed [P_W-1:0]   p0, p1, p2;
  logic signed [ACC_W-1:0] t_ext;
  logic signed [ACC_W-1:0] t_term;
  logic signed [ACC_W-1:0] t_reg;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_next;
  logic signed [R_W-1:0]   r;

  assign m0 = x * c0;
  assign m1 = y * c1;
  assign m2 = z * c2;

  // Translation scaled up to the product's fraction, rounding half folded in.
  assign t_ext  = ACC_W'(t);
  assign t_term = (add_t ? (t_ext <<< COEF_FRAC_BITS) : ACC_W'(0)) + HALF;

  assign acc_next = ACC_W'(p0) + ACC_W'(p1) + ACC_W'(p2) + t_reg;

  // Arithmetic shift gives floor, so ties round toward plus infinity.
  assign r = R_W'(acc >>> COEF_FRAC_BITS);

  always_ff @(posedge clk) begin
    if (en.s1) begin
      p0    <= m0;
      p1    <= m1;
      p2    <= m2;
      t_reg <= t_term;
    end
    if (en.s2) begin
      acc <= acc_next;
    end
    if (en.s3) begin
      if (r > HI) begin
        res <= HI[COORD_WIDTH-1:0];
        sat <= 1'b1;
      end else if (r < LO) begin
        res <= LO[COORD_WIDTH-1:0];
        sat <= 1'b1;
      end else begin
        res <= r[COORD_WIDTH-1:0];
        sat <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/affine_vertex_transform_top.sv =====
`default_nettype none

// Channel   Handshake                   Payload
// vertex    in_valid / in_stall         in_x, in_y, in_z, in_last
// result    out_valid / out_stall       out_x, out_y, out_z, saturated, out_last
// config    APB write/read, 64-bit      row_zero .. add_translation at 8*index
//
// One vertex enters per cycle while in_stall is low; it passes the multiply,
// sum and round/saturate stages in order, one vertex per clock unless stalled.
// Synchronous reset clears the stage valid bits and loads the identity transform.
// out_stall freezes only the stages that are full; empty stages keep filling,
// so in_stall rises only when all three stages hold a request.

module affine_vertex_transform_top #(
  parameter int COORD_WIDTH    = 16,
  parameter int COEF_FRAC_BITS = 12
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [avt_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [avt_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic      [avt_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                                 pready,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic signed [COORD_WIDTH-1:0]   in_x,
  input  wire logic signed [COORD_WIDTH-1:0]   in_y,
  input  wire logic signed [COORD_WIDTH-1:0]   in_z,
  input  wire logic                            in_last,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic signed [COORD_WIDTH-1:0]        out_x,
  output logic signed [COORD_WIDTH-1:0]        out_y,
  output logic signed [COORD_WIDTH-1:0]        out_z,
  output logic                                 saturated,
  output logic                                 out_last
);
  import avt_pkg::*;

  logic [ROW_W-1:0] row_zero, row_one, row_two, translation_row;
  logic             add_translation;

  avt_en_t en;
  logic    v1, v2, v3;
  logic    last1, last2, last3;

  logic signed [COORD_WIDTH-1:0] res [DIMS];
  logic [DIMS-1:0]               sat;

  avt_regs #(
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_regs (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .row_zero        (row_zero),
    .row_one         (row_one),
    .row_two         (row_two),
    .translation_row (translation_row),
    .add_translation (add_translation)
  );

  // A stage loads when it is empty or the stage after it moves.
  assign en.s3 = !v3 || !out_stall;
  assign en.s2 = !v2 || en.s3;
  assign en.s1 = !v1 || en.s2;
  assign in_stall = !en.s1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en.s1) v1 <= in_valid;
      if (en.s2) v2 <= v1;
      if (en.s3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s1) last1 <= in_last;
    if (en.s2) last2 <= last1;
    if (en.s3) last3 <= last2;
  end

  for (genvar j = 0; j < DIMS; j++) begin : g_lane
    avt_lane #(
      .COORD_WIDTH    (COORD_WIDTH),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_lane (
      .clk   (clk),
      .en    (en),
      .x     (in_x),
      .y     (in_y),
      .z     (in_z),
      .c0    (row_zero[j*SLOT_BITS +: SLOT_BITS]),
      .c1    (row_one[j*SLOT_BITS +: SLOT_BITS]),
      .c2    (row_two[j*SLOT_BITS +: SLOT_BITS]),
      .t     (translation_row[j*SLOT_BITS +: SLOT_BITS]),
      .add_t (add_translation),
      .res   (res[j]),
      .sat   (sat[j])
    );
  end

  assign out_valid = v3;
  assign out_x     = res[0];
  assign out_y     = res[1];
  assign out_z     = res[2];
  assign saturated = |sat;
  assign out_last  = last3;

endmodule

`default_nettype wire

// ===== hw/rtl/avt_checker.sv =====
`default_nettype none

module avt_checker #(
  parameter int COORD_WIDTH = 16
) (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_stall,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic signed [COORD_WIDTH-1:0] out_x,
  input wire logic signed [COORD_WIDTH-1:0] out_y,
  input wire logic signed [COORD_WIDTH-1:0] out_z,
  input wire logic                          saturated,
  input wire logic                          out_last
);

  localparam logic [COORD_WIDTH-1:0] MAXV = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic [COORD_WIDTH-1:0] MINV = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  // A pending result is held until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_x) && $stable(out_y)
      && $stable(out_z) && $stable(saturated) && $stable(out_last))
    else $error("result changed while stalled");

  // Input backs up only when the output side is blocked.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("in_stall without output backpressure");

  // A clamped result has at least one component at a rail.
  a_sat_rail: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |->
      (out_x == MAXV) || (out_x == MINV) || (out_y == MAXV) || (out_y == MINV)
      || (out_z == MAXV) || (out_z == MINV))
    else $error("saturated set with no component at a rail");

  // Pipeline is empty right after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind affine_vertex_transform_top avt_checker #(
  .COORD_WIDTH(COORD_WIDTH)
) u_avt_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_x     (out_x),
  .out_y     (out_y),
  .out_z     (out_z),
  .saturated (saturated),
  .out_last  (out_last)
);

`default_nettype wire
